// File: sv/wig_pkg.sv
package wig_pkg;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int PHASE_BITS_DEF   = 32;
    localparam int NUM_TERMS        = 8;

    // 1/(2*pi) as a Q0.48 fraction of a turn
    localparam logic [63:0] INV_TWO_PI_Q48 = 64'h0000_28BE_60DB_9391;

    localparam logic [63:0] K_SEED_X = (64'd1618 * INV_TWO_PI_Q48 + 64'd500) / 64'd1000;
    localparam logic [63:0] K_SEED_Y = (64'd2718 * INV_TWO_PI_Q48 + 64'd500) / 64'd1000;
    localparam logic [63:0] K_IDX_X  = (64'd2399 * INV_TWO_PI_Q48 + 64'd500) / 64'd1000;
    localparam logic [63:0] K_IDX_Y  = (64'd3141 * INV_TWO_PI_Q48 + 64'd500) / 64'd1000;

    localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    typedef enum logic [1:0] {
        REG_AMPLITUDE = 2'd0,
        REG_FREQUENCY = 2'd1,
        REG_SEED      = 2'd2
    } cfg_reg_t;

    // One angle on its way through the series cells. Between the two halves of
    // a cell, acc_s and acc_c hold the product x2*acc before the division.
    typedef struct packed {
        logic [1:0]         quad;
        logic [30:0]        x;
        logic [31:0]        x2;
        logic [31:0]        acc_s;
        logic [31:0]        acc_c;
        logic signed [15:0] point;
    } wig_lane_t;

    function automatic int unsigned sin_div(input int step);
        int unsigned d;
        case (step)
            0:       d = 272;
            1:       d = 210;
            2:       d = 156;
            3:       d = 110;
            4:       d = 72;
            5:       d = 42;
            6:       d = 20;
            default: d = 6;
        endcase
        return d;
    endfunction

    function automatic int unsigned cos_div(input int step);
        int unsigned d;
        case (step)
            0:       d = 240;
            1:       d = 182;
            2:       d = 132;
            3:       d = 90;
            4:       d = 56;
            5:       d = 30;
            6:       d = 12;
            default: d = 2;
        endcase
        return d;
    endfunction

endpackage

// File: sv/wig_if.sv
interface wig_vertex_if;
    logic               valid;
    logic               ready;
    logic [9:0]         vertex_index;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic [31:0]        frame_time;

    modport source (output valid, vertex_index, point_x, point_y, frame_time, input ready);
    modport sink   (input valid, vertex_index, point_x, point_y, frame_time, output ready);
endinterface

interface wig_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;

    modport source (output valid, out_x, out_y, input ready);
    modport sink   (input valid, out_x, out_y, output ready);
endinterface

// File: sv/wig_cell.sv
module wig_cell #(
    parameter int STEP = 0
) (
    input  logic               clk,
    input  logic               en_a,
    input  logic               en_b,
    input  wig_pkg::wig_lane_t lane_in,
    output wig_pkg::wig_lane_t lane_out
);
    import wig_pkg::*;

    localparam int unsigned DS   = sin_div(STEP);
    localparam int unsigned DC   = cos_div(STEP);
    localparam int          SH_S = 32 + $clog2(DS);
    localparam int          SH_C = 32 + $clog2(DC);
    localparam logic [33:0] RCP_S = 34'(((64'd1 << SH_S) + 64'(DS) - 64'd1) / 64'(DS));
    localparam logic [33:0] RCP_C = 34'(((64'd1 << SH_C) + 64'(DC) - 64'd1) / 64'(DC));

    wig_lane_t   a_reg, a_next;
    wig_lane_t   b_reg, b_next;
    logic [63:0] prod_s, prod_c;
    logic [65:0] qp_s, qp_c;
    logic [65:0] q_s, q_c;

    // first half: x2 * acc in Q30
    always_comb
    begin
        prod_s       = 64'(lane_in.x2) * 64'(lane_in.acc_s);
        prod_c       = 64'(lane_in.x2) * 64'(lane_in.acc_c);
        a_next       = lane_in;
        a_next.acc_s = prod_s[61:30];
        a_next.acc_c = prod_c[61:30];
    end

    // second half: divide by the term constant through its reciprocal, subtract from one
    always_comb
    begin
        qp_s         = 66'(a_reg.acc_s) * 66'(RCP_S);
        qp_c         = 66'(a_reg.acc_c) * 66'(RCP_C);
        q_s          = qp_s >> SH_S;
        q_c          = qp_c >> SH_C;
        b_next       = a_reg;
        b_next.acc_s = ONE_Q30 - q_s[31:0];
        b_next.acc_c = ONE_Q30 - q_c[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            a_reg <= a_next;
        end
        if (en_b)
        begin
            b_reg <= b_next;
        end
    end

    assign lane_out = b_reg;

endmodule

// File: sv/vertex_sine_wiggle_core.sv
// Vertex sine wiggle: displaces each vertex by amplitude*sin on x and
// amplitude*cos on y, with a phase made from frame time, frequency, seed and
// vertex index.
// Channels: vertex (sink) takes one vertex per beat; result (source) gives one
// displaced vertex per beat, in order. Both use valid/ready.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 amplitude,
// 1 frequency, 2 seed); index 3 is ignored. Write only while the block is empty.
// Throughput: one vertex per cycle while vertex.ready is high. The datapath is a
// 26-stage pipeline; the sine and cosine series run through two rows of 8 cells,
// one for x and one for y, two stages per cell, one series term per cell.
// Stall: each stage holds when it is full and the next one holds, so empty
// stages keep filling while a result waits; vertex.ready drops only when all
// stages are full and result.ready is low.
// Reset: all stages empty; amplitude 0, frequency 1.0, seed 0.
module vertex_sine_wiggle_core #(
    parameter int MAX_VERTICES = wig_pkg::MAX_VERTICES_DEF,
    parameter int PHASE_BITS   = wig_pkg::PHASE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    wig_vertex_if.sink          vertex,
    wig_result_if.source        result
);
    import wig_pkg::*;

    localparam int          NST     = 26;
    localparam int          CELL0   = 6;
    localparam logic [19:0] RECIP   = 20'((64'd1 << 20) / 64'(MAX_VERTICES));
    localparam logic [16:0] MV      = 17'(MAX_VERTICES);
    localparam logic [31:0] PH_MASK = ~((32'd1 << (32 - PHASE_BITS)) - 32'd1);

    logic [15:0] amp_reg;
    logic [15:0] freq_reg;
    logic [31:0] seed_reg;

    logic [NST-1:0] vld_reg;
    logic [NST:0]   en;

    // stage 0
    logic [29:0]        s0_iq_reg, s0_iq_next;
    logic [9:0]         s0_idx_reg;
    logic [23:0]        s0_tf_reg, s0_tf_next;
    logic [47:0]        s0_sxlo_reg, s0_sxlo_next, s0_sylo_reg, s0_sylo_next;
    logic [23:0]        s0_sxhi_reg, s0_sxhi_next, s0_syhi_reg, s0_syhi_next;
    logic signed [15:0] s0_px_reg, s0_py_reg;
    logic [39:0]        tf_prod;
    logic [55:0]        sxlo_prod, sylo_prod;
    logic [47:0]        sxhi_prod, syhi_prod;

    // stage 1
    logic [9:0]         s1_r_reg, s1_r_next;
    logic [23:0]        s1_tf_reg;
    logic [47:0]        s1_sx_reg, s1_sx_next, s1_sy_reg, s1_sy_next;
    logic signed [15:0] s1_px_reg, s1_py_reg;
    logic [26:0]        qm_prod;

    // stage 2
    logic [9:0]         idx_m;
    logic [33:0]        s2_ixlo_reg, s2_ixlo_next, s2_iylo_reg, s2_iylo_next;
    logic [23:0]        s2_ixhi_reg, s2_ixhi_next, s2_iyhi_reg, s2_iyhi_next;
    logic [33:0]        ixhi_prod, iyhi_prod;
    logic [23:0]        s2_tf_reg;
    logic [47:0]        s2_sx_reg, s2_sy_reg;
    logic signed [15:0] s2_px_reg, s2_py_reg;

    // stage 3
    logic [47:0]        ph_x, ph_y;
    logic [31:0]        p32_x, p32_y;
    logic [1:0]         s3_qx_reg, s3_qy_reg;
    logic [29:0]        s3_rx_reg, s3_ry_reg;
    logic signed [15:0] s3_px_reg, s3_py_reg;

    // stage 4
    logic [60:0]        xr_prod, yr_prod;
    logic [30:0]        s4_xx_reg, s4_xy_reg;
    logic [1:0]         s4_qx_reg, s4_qy_reg;
    logic signed [15:0] s4_px_reg, s4_py_reg;

    // stage 5 and the cell row
    wig_lane_t   l5x_next, l5y_next;
    wig_lane_t   lane_x [NUM_TERMS+1];
    wig_lane_t   lane_y [NUM_TERMS+1];
    wig_lane_t   l5x_reg, l5y_reg;
    logic [61:0] xsq_x, xsq_y;

    // stages 22..25
    logic [63:0]        sin_px, sin_py;
    logic signed [31:0] trig_x_reg, trig_x_next, trig_y_reg, trig_y_next;
    logic signed [15:0] s22_px_reg, s22_py_reg;
    logic signed [48:0] disp_x_reg, disp_x_next, disp_y_reg, disp_y_next;
    logic signed [15:0] s23_px_reg, s23_py_reg;
    logic signed [55:0] tot_x_reg, tot_x_next, tot_y_reg, tot_y_next;
    logic signed [15:0] ox_reg, ox_next, oy_reg, oy_next;

    function automatic logic signed [31:0] quad_sel(input logic [1:0] q,
                                                    input logic [31:0] s,
                                                    input logic [31:0] c);
        logic signed [31:0] v;
        case (q)
            2'd0:    v = $signed(s);
            2'd1:    v = $signed(c);
            2'd2:    v = -$signed(s);
            default: v = -$signed(c);
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] round_sat(input logic signed [55:0] t);
        logic        neg;
        logic [55:0] mag;
        logic [17:0] vm;
        logic signed [15:0] v;
        neg = t[55];
        mag = (neg ? 56'(-t) : 56'(t)) + (56'd1 << 37);
        vm  = mag[55:38];
        if (!neg)
        begin
            v = (vm > 18'd32767) ? 16'sh7FFF : $signed(vm[15:0]);
        end
        else
        begin
            v = (vm > 18'd32768) ? 16'sh8000 : $signed(16'(-vm));
        end
        return v;
    endfunction

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_reg  <= 16'd0;
            freq_reg <= 16'd256;
            seed_reg <= 32'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_AMPLITUDE: amp_reg  <= cfg_data[15:0];
                REG_FREQUENCY: freq_reg <= cfg_data[15:0];
                REG_SEED:      seed_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // hold a stage only when it is full and the one after it holds
    always_comb
    begin
        en[NST] = result.ready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= vertex.valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign vertex.ready = en[0];

    // stage 0: time * frequency, seed partial products, index reciprocal
    always_comb
    begin
        s0_iq_next   = 30'(vertex.vertex_index) * 30'(RECIP);
        tf_prod      = 40'(vertex.frame_time[23:0]) * 40'(freq_reg);
        s0_tf_next   = tf_prod[23:0];
        sxlo_prod    = 56'(seed_reg) * 56'(K_SEED_X[23:0]);
        sylo_prod    = 56'(seed_reg) * 56'(K_SEED_Y[23:0]);
        sxhi_prod    = 48'(seed_reg[23:0]) * 48'(K_SEED_X[47:24]);
        syhi_prod    = 48'(seed_reg[23:0]) * 48'(K_SEED_Y[47:24]);
        s0_sxlo_next = sxlo_prod[47:0];
        s0_sylo_next = sylo_prod[47:0];
        s0_sxhi_next = sxhi_prod[23:0];
        s0_syhi_next = syhi_prod[23:0];
    end

    // stage 1: remainder estimate, seed terms
    always_comb
    begin
        qm_prod    = 27'(s0_iq_reg[29:20]) * 27'(MV);
        s1_r_next  = s0_idx_reg - qm_prod[9:0];
        s1_sx_next = {s0_sxhi_reg, 24'd0} + s0_sxlo_reg;
        s1_sy_next = {s0_syhi_reg, 24'd0} + s0_sylo_reg;
    end

    // stage 2: finish the index reduction, index partial products
    always_comb
    begin
        idx_m        = ({7'd0, s1_r_reg} >= MV) ? (s1_r_reg - MV[9:0]) : s1_r_reg;
        s2_ixlo_next = 34'(idx_m) * 34'(K_IDX_X[23:0]);
        s2_iylo_next = 34'(idx_m) * 34'(K_IDX_Y[23:0]);
        ixhi_prod    = 34'(idx_m) * 34'(K_IDX_X[47:24]);
        iyhi_prod    = 34'(idx_m) * 34'(K_IDX_Y[47:24]);
        s2_ixhi_next = ixhi_prod[23:0];
        s2_iyhi_next = iyhi_prod[23:0];
    end

    // stage 3: phase sums modulo one turn
    always_comb
    begin
        ph_x  = {s2_tf_reg, 24'd0} + s2_sx_reg + {s2_ixhi_reg, 24'd0} + 48'(s2_ixlo_reg);
        ph_y  = {s2_tf_reg, 24'd0} + s2_sy_reg + {s2_iyhi_reg, 24'd0} + 48'(s2_iylo_reg);
        p32_x = ph_x[47:16] & PH_MASK;
        p32_y = ph_y[47:16] & PH_MASK;
    end

    // stage 4: angle within the quadrant in Q1.30 radians
    always_comb
    begin
        xr_prod = 61'(s3_rx_reg) * 61'(HALF_PI_Q30);
        yr_prod = 61'(s3_ry_reg) * 61'(HALF_PI_Q30);
    end

    // stage 5: square, seed the series
    always_comb
    begin
        xsq_x          = 62'(s4_xx_reg) * 62'(s4_xx_reg);
        xsq_y          = 62'(s4_xy_reg) * 62'(s4_xy_reg);
        l5x_next.quad  = s4_qx_reg;
        l5x_next.x     = s4_xx_reg;
        l5x_next.x2    = xsq_x[61:30];
        l5x_next.acc_s = ONE_Q30;
        l5x_next.acc_c = ONE_Q30;
        l5x_next.point = s4_px_reg;
        l5y_next.quad  = s4_qy_reg;
        l5y_next.x     = s4_xy_reg;
        l5y_next.x2    = xsq_y[61:30];
        l5y_next.acc_s = ONE_Q30;
        l5y_next.acc_c = ONE_Q30;
        l5y_next.point = s4_py_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_iq_reg   <= s0_iq_next;
            s0_idx_reg  <= vertex.vertex_index;
            s0_tf_reg   <= s0_tf_next;
            s0_sxlo_reg <= s0_sxlo_next;
            s0_sylo_reg <= s0_sylo_next;
            s0_sxhi_reg <= s0_sxhi_next;
            s0_syhi_reg <= s0_syhi_next;
            s0_px_reg   <= vertex.point_x;
            s0_py_reg   <= vertex.point_y;
        end
        if (en[1])
        begin
            s1_r_reg  <= s1_r_next;
            s1_tf_reg <= s0_tf_reg;
            s1_sx_reg <= s1_sx_next;
            s1_sy_reg <= s1_sy_next;
            s1_px_reg <= s0_px_reg;
            s1_py_reg <= s0_py_reg;
        end
        if (en[2])
        begin
            s2_ixlo_reg <= s2_ixlo_next;
            s2_iylo_reg <= s2_iylo_next;
            s2_ixhi_reg <= s2_ixhi_next;
            s2_iyhi_reg <= s2_iyhi_next;
            s2_tf_reg   <= s1_tf_reg;
            s2_sx_reg   <= s1_sx_reg;
            s2_sy_reg   <= s1_sy_reg;
            s2_px_reg   <= s1_px_reg;
            s2_py_reg   <= s1_py_reg;
        end
        if (en[3])
        begin
            s3_qx_reg <= p32_x[31:30];
            // cosine is sine one quadrant ahead
            s3_qy_reg <= p32_y[31:30] + 2'd1;
            s3_rx_reg <= p32_x[29:0];
            s3_ry_reg <= p32_y[29:0];
            s3_px_reg <= s2_px_reg;
            s3_py_reg <= s2_py_reg;
        end
        if (en[4])
        begin
            s4_xx_reg <= xr_prod[60:30];
            s4_xy_reg <= yr_prod[60:30];
            s4_qx_reg <= s3_qx_reg;
            s4_qy_reg <= s3_qy_reg;
            s4_px_reg <= s3_px_reg;
            s4_py_reg <= s3_py_reg;
        end
        if (en[5])
        begin
            l5x_reg <= l5x_next;
            l5y_reg <= l5y_next;
        end
    end

    assign lane_x[0] = l5x_reg;
    assign lane_y[0] = l5y_reg;

    for (genvar j = 0; j < NUM_TERMS; j++)
    begin : g_cell
        wig_cell #(.STEP(j)) u_cell_x (
            .clk      (clk),
            .en_a     (en[CELL0 + 2*j]),
            .en_b     (en[CELL0 + 2*j + 1]),
            .lane_in  (lane_x[j]),
            .lane_out (lane_x[j+1])
        );
        wig_cell #(.STEP(j)) u_cell_y (
            .clk      (clk),
            .en_a     (en[CELL0 + 2*j]),
            .en_b     (en[CELL0 + 2*j + 1]),
            .lane_in  (lane_y[j]),
            .lane_out (lane_y[j+1])
        );
    end

    // stage 22: finish sine, place by quadrant
    always_comb
    begin
        sin_px      = 64'(lane_x[NUM_TERMS].x) * 64'(lane_x[NUM_TERMS].acc_s);
        sin_py      = 64'(lane_y[NUM_TERMS].x) * 64'(lane_y[NUM_TERMS].acc_s);
        trig_x_next = quad_sel(lane_x[NUM_TERMS].quad, sin_px[61:30], lane_x[NUM_TERMS].acc_c);
        trig_y_next = quad_sel(lane_y[NUM_TERMS].quad, sin_py[61:30], lane_y[NUM_TERMS].acc_c);
    end

    // stages 23..25: scale, add to the point, round and saturate
    always_comb
    begin
        disp_x_next = $signed({1'b0, amp_reg}) * trig_x_reg;
        disp_y_next = $signed({1'b0, amp_reg}) * trig_y_reg;
        tot_x_next  = $signed({{2{s23_px_reg[15]}}, s23_px_reg, 38'd0})
                      + $signed({{7{disp_x_reg[48]}}, disp_x_reg});
        tot_y_next  = $signed({{2{s23_py_reg[15]}}, s23_py_reg, 38'd0})
                      + $signed({{7{disp_y_reg[48]}}, disp_y_reg});
        ox_next     = round_sat(tot_x_reg);
        oy_next     = round_sat(tot_y_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[22])
        begin
            trig_x_reg <= trig_x_next;
            trig_y_reg <= trig_y_next;
            s22_px_reg <= lane_x[NUM_TERMS].point;
            s22_py_reg <= lane_y[NUM_TERMS].point;
        end
        if (en[23])
        begin
            disp_x_reg <= disp_x_next;
            disp_y_reg <= disp_y_next;
            s23_px_reg <= s22_px_reg;
            s23_py_reg <= s22_py_reg;
        end
        if (en[24])
        begin
            tot_x_reg <= tot_x_next;
            tot_y_reg <= tot_y_next;
        end
        if (en[25])
        begin
            ox_reg <= ox_next;
            oy_reg <= oy_next;
        end
    end

    assign result.valid = vld_reg[NST-1];
    assign result.out_x = ox_reg;
    assign result.out_y = oy_reg;

`ifndef SYNTHESIS
    a_full_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !vertex.ready |-> ((&vld_reg) && !result.ready))
        else $error("input stalled while the pipeline has room");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (vertex.valid && vertex.ready) |=> vld_reg[0])
        else $error("accepted vertex missing from first stage");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NST-1] && !result.ready) |=> (vld_reg[NST-1] && $stable(ox_reg)))
        else $error("stalled result register changed");
`endif

endmodule
